// ===== rtl/core/tap_tempo_estimator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// tap tempo estimator assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TTE_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

`define TTE_ASSERT(label, prop, msg) \
	`TTE_ASSERT_CLK(label, clk, arst_n, prop, msg)

`else

`define TTE_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg)

`define TTE_ASSERT(label, prop, msg)

`endif

`endif

// ===== rtl/core/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tap tempo estimator package
// item types, command codes, sequencer states and fixed widths
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int CMD_W     = 3;
	localparam int BPM_W     = 16;
	localparam int TPS_W     = 20;
	localparam int CNT_W     = 32;
	localparam int TAP_W     = 8;
	localparam int PER_MIN_W = 26;

	localparam logic [PER_MIN_W-1:0] SEC_PER_MIN = PER_MIN_W'(60);
	localparam logic [TPS_W-1:0]     TPS_RESET   = TPS_W'(1000);
	localparam logic [BPM_W-1:0]     BPM_MAX     = '1;
	localparam logic [TAP_W-1:0]     TAP_MAX     = '1;

	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TAP        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_BPM    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLR_MINMAX = 3'd5;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [BPM_W-1:0] new_bpm;
	} cmd_item_t;

	typedef struct packed {
		logic [BPM_W-1:0] bpm_now;
		logic [BPM_W-1:0] bpm_low;
		logic [BPM_W-1:0] bpm_high;
		logic [CNT_W-1:0] beat_period;
		logic             period_valid;
		logic             learning;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_DIV,
		ST_EMIT
	} tte_state_t;

	typedef enum logic [2:0] {
		OP_AVG,
		OP_SLOW,
		OP_FAST,
		OP_PERIOD,
		OP_MEAN
	} div_op_t;

endpackage

// ===== rtl/core/tte_stream_if.sv =====
// ----------------------------------------------------------------------------
// tap tempo estimator stream interface
// valid/ready channel carrying one payload item per transaction
// ----------------------------------------------------------------------------
interface tte_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/tap_tempo_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// tap tempo estimator
// learns a tempo from tap commands, reports bpm and beat period per command
// ----------------------------------------------------------------------------
// channel    dir  payload                                             handshake
// cmd_ch     in   cmd, new_bpm                                        valid/ready
// res_ch     out  bpm_now, bpm_low, bpm_high, beat_period,            valid/ready
//                 period_valid, learning
// cfg        in   cfg_wdata (ticks_per_second)                        cfg_we
//
// non-query: accept, then result register load once the output slot is free
// query: scan of the SAMPLES ring entries, then up to four divisions (average tempo,
// slowest, fastest, beat period or mean interval) on the shared restoring divider,
// one quotient bit per cycle
// DIV_W = 32 + clog2(SAMPLES), 34 bits at SAMPLES = 3
// no clearing pass after reset; a stalled result holds the block in its last step
// ----------------------------------------------------------------------------
`include "tap_tempo_estimator_unit_defines.svh"

module tap_tempo_estimator_unit #(
	parameter int SAMPLES = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tte_pkg::TPS_W-1:0] cfg_wdata,
	tte_stream_if.sink               cmd_ch,
	tte_stream_if.source             res_ch
);

	localparam int IDX_W  = $clog2(SAMPLES);
	localparam int DIV_W  = tte_pkg::CNT_W + $clog2(SAMPLES);
	localparam int DCNT_W = $clog2(DIV_W);
	localparam int CNT_W  = tte_pkg::CNT_W;
	localparam int BPM_W  = tte_pkg::BPM_W;
	localparam int TAP_W  = tte_pkg::TAP_W;

	tte_pkg::tte_state_t state_q, state_d;
	tte_pkg::div_op_t    op_q;

	logic [tte_pkg::TPS_W-1:0]     tps_q;
	logic [tte_pkg::PER_MIN_W-1:0] per_min_q;
	logic [CNT_W-1:0]              icnt_q;
	logic [CNT_W-1:0]              ring_q [SAMPLES];
	logic [IDX_W-1:0]              wr_pos_q;
	logic [TAP_W-1:0]              tap_total_q;
	logic                          learn_q;
	logic [BPM_W-1:0]              bpm_q;
	logic [BPM_W-1:0]              slow_q;
	logic [BPM_W-1:0]              fast_q;
	logic [CNT_W-1:0]              pcache_q;

	logic [IDX_W-1:0]  idx_q;
	logic [DIV_W-1:0]  sum_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  period_q;
	logic              valid_q;

	logic [DIV_W-1:0]  div_rem_q;
	logic [DIV_W-1:0]  div_quo_q;
	logic [DIV_W-1:0]  div_den_q;
	logic [DCNT_W-1:0] div_cnt_q;

	logic                 out_valid_q;
	tte_pkg::res_item_t   out_q;

	logic             in_fire;
	logic             slot_free;
	logic             enough;
	logic [DIV_W:0]   div_shift;
	logic [DIV_W:0]   div_diff;
	logic             div_ge;
	logic             div_done;
	logic [DIV_W-1:0] div_q_next;
	logic [BPM_W-1:0] quo_sat;
	logic [CNT_W-1:0] scan_val;

	logic                plan_start;
	logic                plan_fin;
	tte_pkg::div_op_t    plan_op;
	logic [DIV_W-1:0]    plan_num;
	logic [DIV_W-1:0]    plan_den;
	logic [CNT_W-1:0]    plan_period;
	logic                plan_valid;

	assign cmd_ch.ready  = (state_q == tte_pkg::ST_IDLE);
	assign in_fire       = cmd_ch.valid && cmd_ch.ready;
	assign res_ch.valid  = out_valid_q;
	assign res_ch.payload = out_q;
	assign slot_free     = !out_valid_q || res_ch.ready;
	assign enough        = (tap_total_q >= TAP_W'(SAMPLES));
	assign scan_val      = ring_q[idx_q];

	// restoring divider step
	assign div_shift  = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_diff   = div_shift - {1'b0, div_den_q};
	assign div_ge     = (div_shift >= {1'b0, div_den_q});
	assign div_done   = (state_q == tte_pkg::ST_DIV) && (div_cnt_q == DCNT_W'(DIV_W - 1));
	assign div_q_next = {div_quo_q[DIV_W-2:0], div_ge};
	assign quo_sat    = (|div_q_next[DIV_W-1:BPM_W]) ? tte_pkg::BPM_MAX
	                                                : div_q_next[BPM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		plan_start  = 1'b0;
		plan_fin    = 1'b0;
		plan_op     = op_q;
		plan_num    = '0;
		plan_den    = '0;
		plan_period = '0;
		plan_valid  = 1'b0;
		unique case (state_q)
			tte_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (cmd_ch.payload.cmd == tte_pkg::CMD_QUERY) ? tte_pkg::ST_SCAN
					                                                     : tte_pkg::ST_EMIT;
				end
			end
			tte_pkg::ST_SCAN: begin
				if (idx_q == IDX_W'(SAMPLES - 1)) begin
					state_d = tte_pkg::ST_PLAN;
				end
			end
			tte_pkg::ST_PLAN: begin
				unique case (op_q)
					tte_pkg::OP_AVG: begin
						if (enough && bpm_q == '0) begin
							plan_start = 1'b1;
							plan_op    = tte_pkg::OP_AVG;
							plan_num   = DIV_W'(per_min_q) * DIV_W'(SAMPLES);
							plan_den   = sum_q;
						end
					end
					tte_pkg::OP_SLOW: begin
						plan_start = 1'b1;
						plan_op    = tte_pkg::OP_SLOW;
						plan_num   = DIV_W'(per_min_q);
						plan_den   = DIV_W'(hi_q);
					end
					tte_pkg::OP_FAST: begin
						plan_start = 1'b1;
						plan_op    = tte_pkg::OP_FAST;
						plan_num   = DIV_W'(per_min_q);
						plan_den   = DIV_W'(lo_q);
					end
					tte_pkg::OP_PERIOD: begin
						priority if (bpm_q != '0) begin
							plan_start = 1'b1;
							plan_op    = tte_pkg::OP_PERIOD;
							plan_num   = DIV_W'(per_min_q);
							plan_den   = DIV_W'(bpm_q);
						end else if (pcache_q != '0) begin
							plan_fin    = 1'b1;
							plan_period = pcache_q;
							plan_valid  = 1'b1;
						end else if (enough) begin
							plan_start = 1'b1;
							plan_op    = tte_pkg::OP_MEAN;
							plan_num   = sum_q;
							plan_den   = DIV_W'(SAMPLES);
						end else begin
							plan_fin = 1'b1;
						end
					end
					default: begin
						plan_fin    = 1'b1;
						plan_period = period_q;
						plan_valid  = valid_q;
					end
				endcase
				if (plan_start) begin
					state_d = tte_pkg::ST_DIV;
				end else if (plan_fin) begin
					state_d = tte_pkg::ST_EMIT;
				end
			end
			tte_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (op_q == tte_pkg::OP_PERIOD || op_q == tte_pkg::OP_MEAN)
					        ? tte_pkg::ST_EMIT : tte_pkg::ST_PLAN;
				end
			end
			tte_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = tte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tte_pkg::ST_IDLE;
			end
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= tte_pkg::TPS_RESET;
			icnt_q      <= '0;
			wr_pos_q    <= '0;
			tap_total_q <= '0;
			learn_q     <= 1'b0;
			bpm_q       <= '0;
			slow_q      <= '0;
			fast_q      <= '0;
			pcache_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			if (in_fire) begin
				unique case (cmd_ch.payload.cmd)
					tte_pkg::CMD_TICK: begin
						if (learn_q && icnt_q != '1) begin
							icnt_q <= icnt_q + 1'b1;
						end
					end
					tte_pkg::CMD_TAP: begin
						if (learn_q) begin
							wr_pos_q <= (wr_pos_q == IDX_W'(SAMPLES - 1)) ? '0
							                                              : wr_pos_q + 1'b1;
							if (tap_total_q != tte_pkg::TAP_MAX) begin
								tap_total_q <= tap_total_q + 1'b1;
							end
							icnt_q <= '0;
						end
					end
					tte_pkg::CMD_START: begin
						if (!learn_q) begin
							learn_q     <= 1'b1;
							icnt_q      <= '0;
							tap_total_q <= '0;
							wr_pos_q    <= '0;
							bpm_q       <= '0;
							slow_q      <= '0;
							fast_q      <= '0;
							pcache_q    <= '0;
						end
					end
					tte_pkg::CMD_STOP: begin
						learn_q <= 1'b0;
					end
					tte_pkg::CMD_SET_BPM: begin
						bpm_q <= cmd_ch.payload.new_bpm;
					end
					tte_pkg::CMD_CLR_MINMAX: begin
						slow_q <= '0;
						fast_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (div_done) begin
				unique case (op_q)
					tte_pkg::OP_AVG:  bpm_q  <= quo_sat;
					tte_pkg::OP_SLOW: slow_q <= quo_sat;
					tte_pkg::OP_FAST: fast_q <= quo_sat;
					default:          pcache_q <= div_q_next[CNT_W-1:0];
				endcase
			end
			if (state_q == tte_pkg::ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the query sequencer and divider
	always_ff @(posedge clk) begin
		per_min_q <= {{(tte_pkg::PER_MIN_W - tte_pkg::TPS_W){1'b0}}, tps_q}
		           * tte_pkg::SEC_PER_MIN;
		if (in_fire) begin
			period_q <= '0;
			valid_q  <= 1'b0;
			idx_q    <= '0;
			sum_q    <= '0;
			lo_q     <= '1;
			hi_q     <= '0;
			op_q     <= tte_pkg::OP_AVG;
			if (cmd_ch.payload.cmd == tte_pkg::CMD_TAP && learn_q) begin
				ring_q[wr_pos_q] <= icnt_q;
			end
		end
		if (state_q == tte_pkg::ST_SCAN) begin
			sum_q <= sum_q + DIV_W'(scan_val);
			if (scan_val < lo_q) begin
				lo_q <= scan_val;
			end
			if (scan_val > hi_q) begin
				hi_q <= scan_val;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == tte_pkg::ST_PLAN) begin
			priority if (plan_start) begin
				op_q      <= plan_op;
				div_rem_q <= '0;
				div_quo_q <= plan_num;
				div_den_q <= plan_den;
				div_cnt_q <= '0;
			end else if (plan_fin) begin
				period_q <= plan_period;
				valid_q  <= plan_valid;
			end else begin
				op_q <= tte_pkg::OP_PERIOD;
			end
		end
		if (state_q == tte_pkg::ST_DIV) begin
			div_rem_q <= div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
			div_quo_q <= div_q_next;
			div_cnt_q <= div_cnt_q + 1'b1;
			if (div_done) begin
				unique case (op_q)
					tte_pkg::OP_AVG:  op_q <= tte_pkg::OP_SLOW;
					tte_pkg::OP_SLOW: op_q <= tte_pkg::OP_FAST;
					tte_pkg::OP_FAST: op_q <= tte_pkg::OP_PERIOD;
					default: begin
						period_q <= div_q_next[CNT_W-1:0];
						valid_q  <= 1'b1;
					end
				endcase
			end
		end
		if (state_q == tte_pkg::ST_EMIT && slot_free) begin
			out_q.bpm_now      <= enough ? bpm_q : '0;
			out_q.bpm_low      <= slow_q;
			out_q.bpm_high     <= fast_q;
			out_q.beat_period  <= period_q;
			out_q.period_valid <= valid_q;
			out_q.learning     <= learn_q;
		end
	end

	`TTE_ASSERT(a_nonquery_to_emit, (in_fire && cmd_ch.payload.cmd != tte_pkg::CMD_QUERY) |=> (state_q == tte_pkg::ST_EMIT), "non-query transaction did not go straight to emit")
	`TTE_ASSERT(a_wr_pos_range, wr_pos_q <= IDX_W'(SAMPLES - 1), "ring write position out of range")
	`TTE_ASSERT(a_tap_total_by_cmd, (tap_total_q != $past(tap_total_q)) |-> $past(in_fire), "tap count changed without a command transaction")
	`TTE_ASSERT(a_div_count_range, (state_q == tte_pkg::ST_DIV) |-> (div_cnt_q < DCNT_W'(DIV_W)), "divider step count overran")

endmodule
